>>> src/kmpsm_pkg.sv
// Shared types and constants for the streaming KMP matcher.
package kmpsm_pkg;

  localparam int unsigned MAX_PATTERN_DEF   = 64;
  localparam int unsigned POSITION_BITS_DEF = 32;

  localparam int unsigned SYM_W    = 8;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MLEN_W   = 7;
  localparam int unsigned START_W  = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_APPEND  = 2'd1,
    MODE_TEXT    = 2'd2,
    MODE_RESTART = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Broadcast to every cell of the row for one beat.
  typedef struct packed {
    logic             wr_en;   // write symbol into the cell at the pattern tail
    logic             txt_en;  // shift the partial-match bits by one text byte
    logic             flush;   // drop every partial match
    logic [SYM_W-1:0] symbol;
  } cell_ctrl_t;

endpackage

>>> src/kmpsm_cell.sv
// One pattern position: its byte and the partial-match bit for its prefix length.
module kmpsm_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned LEN_W = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kmpsm_pkg::cell_ctrl_t  ctrl_i,
  input  logic [LEN_W-1:0]       plen_i,
  input  logic                   prev_act_i,
  output logic                   act_o,
  output logic                   match_o
);

  localparam logic [LEN_W-1:0] IDX_L = LEN_W'(IDX);

  logic [kmpsm_pkg::SYM_W-1:0] byte_q;
  logic                        act_q, act_d;
  logic                        in_pat, is_last, hit;

  assign in_pat  = IDX_L < plen_i;
  assign is_last = IDX_L == (plen_i - LEN_W'(1));
  assign hit     = prev_act_i & in_pat & (byte_q == ctrl_i.symbol);

  // A completed full match is reported, not kept: the set then holds only borders.
  always_comb begin
    act_d = act_q;
    if (ctrl_i.flush) begin
      act_d = 1'b0;
    end else if (ctrl_i.txt_en) begin
      act_d = hit & ~is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en && (IDX_L == plen_i)) begin
      byte_q <= ctrl_i.symbol;
    end
  end

  assign act_o   = act_q;
  assign match_o = ctrl_i.txt_en & hit & is_last;

endmodule

>>> src/kmpsm_len_tree.sv
// Selection tree giving the longest live partial-match length.
module kmpsm_len_tree #(
  parameter int unsigned N     = 64,
  parameter int unsigned LEN_W = 7
) (
  input  logic [N-1:0]     act_i,
  output logic [LEN_W-1:0] len_o
);

  localparam int unsigned NLEAF = 1 << $clog2(N);

  logic [LEN_W-1:0] node [1:2*NLEAF-1];

  // Higher lengths sit to the right; a non-empty right child wins.
  always_comb begin
    for (int i = 0; i < NLEAF; i++) begin
      node[NLEAF+i] = '0;
      if (i < N) begin
        if (act_i[i]) begin
          node[NLEAF+i] = LEN_W'(i + 1);
        end
      end
    end
    for (int n = NLEAF - 1; n >= 1; n--) begin
      node[n] = (node[2*n+1] != '0) ? node[2*n+1] : node[2*n];
    end
  end

  assign len_o = node[1];

endmodule

>>> src/kmp_stream_matcher_top.sv
// Top level of the streaming KMP matcher: cell row, length tree and result register.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one beat per command:
//   mode_i selects clear all, append pattern byte, text byte or restart text,
//   symbol_i carries the byte for append and text beats.
//   Output channel (out_valid_o / out_ready_i) returns exactly one beat per
//   input beat, in order: found flag, start position of a completed match,
//   current matched prefix length and a status code.
// Flow:
//   A beat is taken into the cell row and the result stage on the accepting
//   edge; its result moves into the output register once that register is
//   free or being drained. A new beat is not accepted until the previous one
//   has left the result stage, which holds the row while the length tree
//   resolves the longest live prefix. The cost of a text byte does not
//   depend on the match history, as every pattern position is compared in
//   parallel in its own cell.
// Reset:
//   Pattern length, match state and text position go to zero; pattern bytes
//   are left as they are and are never read before being appended again.
// Stalls:
//   While out_ready_i is low the finished result is held; one more beat may
//   be accepted and then waits in the result stage until the result is taken.
module kmp_stream_matcher_top #(
  parameter int unsigned MAX_PATTERN   = kmpsm_pkg::MAX_PATTERN_DEF,
  parameter int unsigned POSITION_BITS = kmpsm_pkg::POSITION_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [kmpsm_pkg::MODE_W-1:0]     mode_i,
  input  logic [kmpsm_pkg::SYM_W-1:0]      symbol_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             found_o,
  output logic [kmpsm_pkg::START_W-1:0]    start_position_o,
  output logic [kmpsm_pkg::MLEN_W-1:0]     matched_length_o,
  output logic [kmpsm_pkg::STATUS_W-1:0]   status_o
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned PB    = POSITION_BITS;

  kmpsm_pkg::mode_e      mode;
  kmpsm_pkg::cell_ctrl_t ctrl;
  logic                  accept, full, empty;

  // Pattern length and text position.
  logic [LEN_W-1:0] plen_q, plen_d;
  logic [PB-1:0]    tpos_q, tpos_d;

  // Result stage: one beat waiting for the length tree.
  logic                    busy_q, busy_d;
  logic                    found_q;
  logic [PB-1:0]           start_q;
  kmpsm_pkg::status_e      status_q, status_c;

  // Output register.
  logic                    ovalid_q, ovalid_d;
  logic                    ofound_q;
  logic [kmpsm_pkg::START_W-1:0]  ostart_q;
  logic [kmpsm_pkg::MLEN_W-1:0]   olen_q;
  kmpsm_pkg::status_e      ostatus_q;
  logic                    load_out;

  // Cell row.
  logic [MAX_PATTERN-1:0]  act;
  logic [MAX_PATTERN-1:0]  match;
  logic                    found_c;
  logic [PB-1:0]           start_c;
  logic [LEN_W-1:0]        tree_len;

  assign mode       = kmpsm_pkg::mode_e'(mode_i);
  assign in_ready_o = ~busy_q;
  assign accept     = in_valid_i & in_ready_o;
  assign full       = plen_q >= LEN_W'(MAX_PATTERN);
  assign empty      = plen_q == '0;

  // Broadcast the beat to the row; a refused append or text byte touches nothing.
  always_comb begin
    ctrl.wr_en  = accept & (mode == kmpsm_pkg::MODE_APPEND) & ~full;
    ctrl.txt_en = accept & (mode == kmpsm_pkg::MODE_TEXT) & ~empty;
    ctrl.flush  = accept & ((mode == kmpsm_pkg::MODE_CLEAR) ||
                            (mode == kmpsm_pkg::MODE_RESTART));
    ctrl.symbol = symbol_i;
  end

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic prev_act;
    if (i == 0) begin : g_head
      assign prev_act = 1'b1;
    end else begin : g_link
      assign prev_act = act[i-1];
    end
    kmpsm_cell #(
      .IDX   (i),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .plen_i     (plen_q),
      .prev_act_i (prev_act),
      .act_o      (act[i]),
      .match_o    (match[i])
    );
  end

  assign found_c = |match;
  // Start of the match: modular, from the (possibly saturated) position.
  assign start_c = tpos_q - PB'(plen_q) + PB'(1);

  always_comb begin
    status_c = kmpsm_pkg::ST_OK;
    if ((mode == kmpsm_pkg::MODE_APPEND) && full) begin
      status_c = kmpsm_pkg::ST_FULL;
    end else if ((mode == kmpsm_pkg::MODE_TEXT) && empty) begin
      status_c = kmpsm_pkg::ST_EMPTY;
    end
  end

  always_comb begin
    plen_d = plen_q;
    tpos_d = tpos_q;
    if (accept) begin
      unique case (mode)
        kmpsm_pkg::MODE_CLEAR: begin
          plen_d = '0;
          tpos_d = '0;
        end
        kmpsm_pkg::MODE_APPEND: begin
          if (!full) plen_d = plen_q + LEN_W'(1);
        end
        kmpsm_pkg::MODE_TEXT: begin
          // Saturate the position at its top value.
          if (!empty && (tpos_q != '1)) tpos_d = tpos_q + PB'(1);
        end
        kmpsm_pkg::MODE_RESTART: begin
          tpos_d = '0;
        end
        default: begin
          plen_d = plen_q;
        end
      endcase
    end
  end

  kmpsm_len_tree #(
    .N     (MAX_PATTERN),
    .LEN_W (LEN_W)
  ) u_len_tree (
    .act_i (act),
    .len_o (tree_len)
  );

  assign load_out = busy_q & (~ovalid_q | out_ready_i);

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (load_out) begin
      busy_d = 1'b0;
    end
    ovalid_d = ovalid_q;
    if (load_out) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q   <= '0;
      tpos_q   <= '0;
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      plen_q   <= plen_d;
      tpos_q   <= tpos_d;
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Capture the beat's flags on acceptance; move to the output when free.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      found_q  <= found_c;
      start_q  <= found_c ? start_c : '0;
      status_q <= status_c;
    end
    if (load_out) begin
      ofound_q  <= found_q;
      ostart_q  <= kmpsm_pkg::START_W'(start_q);
      olen_q    <= kmpsm_pkg::MLEN_W'(tree_len);
      ostatus_q <= status_q;
    end
  end

  assign out_valid_o      = ovalid_q;
  assign found_o          = ofound_q;
  assign start_position_o = ostart_q;
  assign matched_length_o = olen_q;
  assign status_o         = ostatus_q;

  // The live prefix is always shorter than the pattern, or empty.
  a_len_below_pattern : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ((tree_len < plen_q) || (tree_len == '0)))
    else $error("live prefix length not below pattern length");

  // A match can only come from a text byte against a non-empty pattern.
  a_found_needs_pattern : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && found_q) |-> ((plen_q != '0) && (status_q == kmpsm_pkg::ST_OK)))
    else $error("match reported without a pattern");

  // An accepted beat always occupies the result stage next.
  a_accept_fills_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("accepted beat lost before the result stage");

  // The result stage only empties into a free or draining output register.
  a_stage_drains_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !accept && !busy_d) |=> ovalid_q)
    else $error("result stage emptied without loading the output");

endmodule
